// ===== hdl/four_level_page_table_walker_macros.svh =====
// Assertion macros for the four-level page table walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication.
`define FLPTW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FLPTW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/flptw_pkg.sv =====
// Types, constants and helpers shared by the page table walker.
package flptw_pkg;

  localparam int VA_W   = 48;
  localparam int ADDR_W = 64;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 9;
  localparam int PAGE_W = 12;

  localparam logic [CFG_W-1:0] TOP_TABLE_BASE_RST = 32'h4113_D000;
  localparam logic [CFG_W-1:0] MEM_BASE_RST       = 32'h4000_0000;

  localparam logic CFG_TOP_TABLE_BASE = 1'b0;
  localparam logic CFG_MEM_BASE       = 1'b1;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_DATA    = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] LEVEL_TOP  = 2'd0;
  localparam logic [1:0] LEVEL_LAST = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [VA_W-1:0]   virtual_address;
    logic [ADDR_W-1:0] entry_data;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } result_t;

  // Table index of one level (0 = top) of a virtual address.
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      2'd3: idx = va[20:12];
      default: idx = '0;
    endcase
    return idx;
  endfunction

  // Entry offset within a table: index times eight, zero-extended.
  function automatic logic [ADDR_W-1:0] entry_offset(input logic [IDX_W-1:0] idx);
    return {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
  endfunction

endpackage

// ===== hdl/flptw_in_reg.sv =====
// Input register stage holding one accepted transaction.
module flptw_in_reg
  import flptw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  logic  advance,
  input  item_t item_in,
  output logic  held_valid,
  output item_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item_in;
    end
  end

endmodule

// ===== hdl/flptw_walk.sv =====
// Walk state, configuration registers and the per-transaction address step.
module flptw_walk
  import flptw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             step,
  input  item_t            item,
  output logic             has_result,
  output result_t          result
);
  `include "four_level_page_table_walker_macros.svh"

  logic [CFG_W-1:0] top_table_base;
  logic [CFG_W-1:0] mem_base;
  logic             walk_busy;
  logic             walk_busy_next;
  logic [1:0]       walk_level;
  logic [1:0]       walk_level_next;
  logic [VA_W-1:0]  saved_vaddr;

  logic [ADDR_W-1:0] ram_ext;
  logic [ADDR_W-1:0] top_base_off;
  logic [ADDR_W-1:0] entry_base;
  logic [1:0]        level_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_table_base <= TOP_TABLE_BASE_RST;
      mem_base       <= MEM_BASE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TOP_TABLE_BASE: top_table_base <= cfg_data;
        CFG_MEM_BASE:       mem_base       <= cfg_data;
        default:            ;
      endcase
    end
  end

  assign ram_ext      = {{(ADDR_W-CFG_W){1'b0}}, mem_base};
  assign top_base_off = {{(ADDR_W-CFG_W){1'b0}}, top_table_base} - ram_ext;
  assign entry_base   = {{(ADDR_W-CFG_W){1'b0}}, item.entry_data[31:PAGE_W],
                         {PAGE_W{1'b0}}} - ram_ext;
  assign level_inc    = walk_level + 2'd1;

  always_comb begin
    has_result      = 1'b0;
    result.kind     = KIND_READ;
    result.address  = '0;
    walk_busy_next  = walk_busy;
    walk_level_next = walk_level;
    if (item.mode == MODE_REQUEST) begin
      has_result      = 1'b1;
      result.address  = top_base_off +
                        entry_offset(level_index(item.virtual_address, LEVEL_TOP));
      walk_busy_next  = 1'b1;
      walk_level_next = LEVEL_TOP;
    end else if (walk_busy) begin
      has_result = 1'b1;
      if (walk_level == LEVEL_LAST) begin
        result.kind     = KIND_DONE;
        result.address  = entry_base |
                          {{(ADDR_W-PAGE_W){1'b0}}, saved_vaddr[PAGE_W-1:0]};
        walk_busy_next  = 1'b0;
        walk_level_next = LEVEL_TOP;
      end else begin
        result.address  = entry_base + entry_offset(level_index(saved_vaddr, level_inc));
        walk_level_next = level_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy  <= 1'b0;
      walk_level <= LEVEL_TOP;
    end else if (step) begin
      walk_busy  <= walk_busy_next;
      walk_level <= walk_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.mode == MODE_REQUEST) begin
      saved_vaddr <= item.virtual_address;
    end
  end

  `FLPTW_ASSERT_IMP(a_level_implies_busy, clk, rst, walk_level != LEVEL_TOP, walk_busy, "level set while idle")
  `FLPTW_ASSERT_NXT(a_done_goes_idle, clk, rst, step && has_result && result.kind == KIND_DONE, !walk_busy && walk_level == LEVEL_TOP, "walk not closed after final entry")
  `FLPTW_ASSERT_NXT(a_request_starts, clk, rst, step && item.mode == MODE_REQUEST, walk_busy && walk_level == LEVEL_TOP, "request did not restart walk")

endmodule

// ===== hdl/flptw_out_reg.sv =====
// Result register presenting one transaction to the output channel.
module flptw_out_reg
  import flptw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    result_stall,
  output logic    can_load,
  output logic    result_valid,
  output result_t held
);

  assign can_load = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result_in;
    end
  end

endmodule

// ===== hdl/four_level_page_table_walker.sv =====
// Four-level page table walker, 4 KB granule: top level.
// Takes one transaction per cycle on the item channel, either a translation
// request or the table entry read for the walk in progress, and answers each
// with at most one result: a read request for the next entry or the final
// offset. A transaction passes an input register, then a result register that
// presents its result; the item channel stalls only when the input register
// holds a transaction that has a result while the result register holds one
// that is itself stalled. Read data while idle is dropped; a request mid-walk
// restarts the walk. Configuration must be written through cfg_* only while
// idle; the block itself does not enforce this.
module four_level_page_table_walker
  import flptw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              mode,
  input  logic [VA_W-1:0]   virtual_address,
  input  logic [ADDR_W-1:0] entry_data,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              kind,
  output logic [ADDR_W-1:0] address
);

  item_t   item_in;
  item_t   held_item;
  logic    held_valid;
  logic    has_result;
  logic    can_load;
  logic    advance;
  result_t step_result;
  result_t out_result;

  assign cfg_ready = 1'b1;

  assign item_in.mode            = mode;
  assign item_in.virtual_address = virtual_address;
  assign item_in.entry_data      = entry_data;

  assign advance    = held_valid && (!has_result || can_load);
  assign item_stall = held_valid && !advance;

  flptw_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (item_valid && !item_stall),
    .advance    (advance),
    .item_in    (item_in),
    .held_valid (held_valid),
    .held       (held_item)
  );

  flptw_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (advance),
    .item       (held_item),
    .has_result (has_result),
    .result     (step_result)
  );

  flptw_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && has_result),
    .result_in    (step_result),
    .result_stall (result_stall),
    .can_load     (can_load),
    .result_valid (result_valid),
    .held         (out_result)
  );

  assign kind    = out_result.kind;
  assign address = out_result.address;

endmodule
